// ----- src/rmq_pkg.sv -----
// ---------------------------------------------------------------------------
// Rotation matrix to quaternion: shared package
// Widths, constants, selection codes and the records that travel between
// the front end, the word queue and the arithmetic back end.
// ---------------------------------------------------------------------------
package rmq_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int DATA_W     = 18;
   localparam int DIFF_W     = DATA_W + 1;
   localparam int TRACE_W    = DATA_W + 2;
   localparam int SRAD_W     = DATA_W + 3;
   localparam int RAD_W      = DATA_W + 1;
   localparam int SQN_W      = RAD_W + FRAC_BITS - 2;
   localparam int ROOT_W     = (SQN_W + 1) / 2;
   localparam int SQ_W       = 2 * ROOT_W;
   localparam int DEN_W      = ROOT_W + 2;
   localparam int NUM_W      = DIFF_W + FRAC_BITS + 1;
   localparam int QUO_W      = DATA_W;
   localparam int CMP_W      = NUM_W + 1;
   localparam int DIV_STAGES = QUO_W + 1;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = 2;

   localparam logic signed [DATA_W-1:0] OUT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] OUT_MIN = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic signed [DATA_W-1:0] ONE_Q   = DATA_W'(1 << FRAC_BITS);

   // Which quaternion component receives the half root directly.
   typedef enum logic [1:0] {
      SEL_W,
      SEL_X,
      SEL_Y,
      SEL_Z
   } sel_type;

   typedef struct packed {
      logic [RAD_W-1:0]         rad;
      logic signed [DIFF_W-1:0] d0;
      logic signed [DIFF_W-1:0] d1;
      logic signed [DIFF_W-1:0] d2;
      sel_type                  sel;
      logic                     bad;
   } item_type;

   typedef struct packed {
      logic              vld;
      sel_type           sel;
      logic              bad;
      logic [ROOT_W-1:0] root;
   } meta_type;

endpackage

// ----- src/rmq_front.sv -----
// ---------------------------------------------------------------------------
// Rotation matrix to quaternion: front end
// Accepts a matrix, picks the trace or diagonal case, and forms the radicand
// and the three signed numerators for the back end.
// ---------------------------------------------------------------------------
module rmq_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic signed [rmq_pkg::DATA_W-1:0]   ent [9],
   output logic                                out_valid,
   output rmq_pkg::item_type                   out_item,
   input  logic                                out_ready
);

   logic                       vld_ff, vld_in;
   rmq_pkg::item_type          item_ff, item_in;
   logic                       adv;

   logic signed [rmq_pkg::TRACE_W-1:0] trace;
   logic signed [rmq_pkg::SRAD_W-1:0]  rad;
   logic signed [rmq_pkg::DATA_W-1:0]  aii, ajj, akk;
   rmq_pkg::sel_type                   pick;

   function automatic logic signed [rmq_pkg::DIFF_W-1:0] sub19(
      input logic signed [rmq_pkg::DATA_W-1:0] a,
      input logic signed [rmq_pkg::DATA_W-1:0] b);
      return rmq_pkg::DIFF_W'(a) - rmq_pkg::DIFF_W'(b);
   endfunction

   function automatic logic signed [rmq_pkg::DIFF_W-1:0] add19(
      input logic signed [rmq_pkg::DATA_W-1:0] a,
      input logic signed [rmq_pkg::DATA_W-1:0] b);
      return rmq_pkg::DIFF_W'(a) + rmq_pkg::DIFF_W'(b);
   endfunction

   assign adv      = !vld_ff || out_ready;
   assign in_ready = adv;

   always_comb begin
      trace = rmq_pkg::TRACE_W'(ent[0]) + rmq_pkg::TRACE_W'(ent[4])
            + rmq_pkg::TRACE_W'(ent[8]);
      // Largest diagonal entry; a later one wins only when strictly greater.
      pick = rmq_pkg::SEL_X;
      aii  = ent[0];
      if (ent[4] > aii) begin
         pick = rmq_pkg::SEL_Y;
         aii  = ent[4];
      end
      if (ent[8] > aii) begin
         pick = rmq_pkg::SEL_Z;
         aii  = ent[8];
      end
      unique case (pick)
         rmq_pkg::SEL_Y: begin
            ajj = ent[8];
            akk = ent[0];
         end
         rmq_pkg::SEL_Z: begin
            ajj = ent[0];
            akk = ent[4];
         end
         default: begin
            ajj = ent[4];
            akk = ent[8];
         end
      endcase

      item_in = '0;
      if (trace > 0) begin
         rad          = rmq_pkg::SRAD_W'(trace) + rmq_pkg::SRAD_W'(rmq_pkg::ONE_Q);
         item_in.sel  = rmq_pkg::SEL_W;
         item_in.d0   = sub19(ent[7], ent[5]);
         item_in.d1   = sub19(ent[2], ent[6]);
         item_in.d2   = sub19(ent[3], ent[1]);
      end else begin
         rad = rmq_pkg::SRAD_W'(aii) - rmq_pkg::SRAD_W'(ajj) - rmq_pkg::SRAD_W'(akk)
             + rmq_pkg::SRAD_W'(rmq_pkg::ONE_Q);
         item_in.sel = pick;
         unique case (pick)
            rmq_pkg::SEL_Y: begin
               item_in.d0 = sub19(ent[2], ent[6]);
               item_in.d1 = add19(ent[7], ent[5]);
               item_in.d2 = add19(ent[1], ent[3]);
            end
            rmq_pkg::SEL_Z: begin
               item_in.d0 = sub19(ent[3], ent[1]);
               item_in.d1 = add19(ent[2], ent[6]);
               item_in.d2 = add19(ent[5], ent[7]);
            end
            default: begin
               item_in.d0 = sub19(ent[7], ent[5]);
               item_in.d1 = add19(ent[3], ent[1]);
               item_in.d2 = add19(ent[6], ent[2]);
            end
         endcase
      end
      // A radicand at or below zero gives the identity; the root is unused.
      item_in.bad = (rad <= 0);
      item_in.rad = item_in.bad ? rmq_pkg::RAD_W'(1) : rad[rmq_pkg::RAD_W-1:0];
      vld_in      = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_item  = item_ff;

endmodule

// ----- src/rmq_fifo.sv -----
// ---------------------------------------------------------------------------
// Rotation matrix to quaternion: word queue
// Small first-in first-out queue that decouples the front end from the
// arithmetic back end.
// ---------------------------------------------------------------------------
module rmq_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  rmq_pkg::item_type push_item,
   output logic              pop_valid,
   input  logic              pop_ready,
   output rmq_pkg::item_type pop_item
);

   rmq_pkg::item_type               mem_ff [rmq_pkg::FIFO_DEPTH];
   logic [rmq_pkg::FIFO_AW-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [rmq_pkg::FIFO_AW:0]       cnt_ff, cnt_in;
   logic                            push, pop;

   assign push_ready = (cnt_ff != (rmq_pkg::FIFO_AW+1)'(rmq_pkg::FIFO_DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + (rmq_pkg::FIFO_AW+1)'(push) - (rmq_pkg::FIFO_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (rmq_pkg::FIFO_AW+1)'(rmq_pkg::FIFO_DEPTH))
      else $error("queue count above depth");

   a_cnt_track: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("queue count lost a push");

endmodule

// ----- src/rmq_sqrt.sv -----
// ---------------------------------------------------------------------------
// Rotation matrix to quaternion: pipelined square root
// One root bit per stage, then a rounding stage for the nearest integer.
// The classified word travels alongside.
// ---------------------------------------------------------------------------
module rmq_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  rmq_pkg::item_type           in_item,
   output logic                        out_valid,
   output rmq_pkg::item_type           out_item,
   output logic [rmq_pkg::ROOT_W-1:0]  out_root
);

   localparam int NS = rmq_pkg::ROOT_W;

   logic [rmq_pkg::SQ_W-1:0]   rem_ff [1:NS];
   logic [rmq_pkg::ROOT_W-1:0] res_ff [1:NS];
   logic                       vld_ff [1:NS];
   rmq_pkg::item_type          item_ff [1:NS];
   logic [rmq_pkg::ROOT_W-1:0] root_ff;

   for (genvar s = 0; s < NS; s++) begin : g_stage
      localparam int B = NS - 1 - s;
      logic [rmq_pkg::SQ_W-1:0]   rem_cur;
      logic [rmq_pkg::ROOT_W-1:0] res_cur;
      logic                       vld_cur;
      rmq_pkg::item_type          item_cur;
      logic [rmq_pkg::SQ_W-1:0]   trial;
      logic [rmq_pkg::SQ_W-1:0]   rem_in;
      logic [rmq_pkg::ROOT_W-1:0] res_in;

      // The first stage works straight from the queue output.
      if (s == 0) begin : g_head
         assign rem_cur  = rmq_pkg::SQ_W'(in_item.rad) << (rmq_pkg::FRAC_BITS - 2);
         assign res_cur  = '0;
         assign vld_cur  = in_valid;
         assign item_cur = in_item;
      end else begin : g_body
         assign rem_cur  = rem_ff[s];
         assign res_cur  = res_ff[s];
         assign vld_cur  = vld_ff[s];
         assign item_cur = item_ff[s];
      end

      always_comb begin
         trial = (rmq_pkg::SQ_W'(res_cur) << (B + 1)) + (rmq_pkg::SQ_W'(1) << (2 * B));
         if (rem_cur >= trial) begin
            rem_in = rem_cur - trial;
            res_in = res_cur | (rmq_pkg::ROOT_W'(1) << B);
         end else begin
            rem_in = rem_cur;
            res_in = res_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s+1] <= 1'b0;
         end else if (en) begin
            vld_ff[s+1] <= vld_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s+1]  <= rem_in;
            res_ff[s+1]  <= res_in;
            item_ff[s+1] <= item_cur;
         end
      end
   end

   // Round up when the remainder exceeds the floor root.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else if (en) begin
         out_valid <= vld_ff[NS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         root_ff  <= (rem_ff[NS] > rmq_pkg::SQ_W'(res_ff[NS])) ? res_ff[NS] + 1'b1
                                                                 : res_ff[NS];
         out_item <= item_ff[NS];
      end
   end

   assign out_root = root_ff;

endmodule

// ----- src/rmq_div.sv -----
// ---------------------------------------------------------------------------
// Rotation matrix to quaternion: pipelined scaled divider
// Computes d * 2^FRAC_BITS / (4 h) rounded to nearest, ties away from zero,
// one quotient bit per stage, saturated to the output range.
// ---------------------------------------------------------------------------
module rmq_div (
   input  logic                               clock,
   input  logic                               en,
   input  logic signed [rmq_pkg::DIFF_W-1:0]  num_in,
   input  logic [rmq_pkg::ROOT_W-1:0]         root_in,
   output logic signed [rmq_pkg::DATA_W-1:0]  quo_out
);

   localparam int NS = rmq_pkg::QUO_W;

   logic [rmq_pkg::NUM_W-1:0] rem_ff [NS+1];
   logic [rmq_pkg::DEN_W-1:0] den_ff [NS+1];
   logic [rmq_pkg::QUO_W-1:0] quo_ff [NS+1];
   logic                      neg_ff [NS+1];
   logic                      ovf_ff [NS+1];

   logic                      neg0, ovf0;
   logic [rmq_pkg::DIFF_W-1:0] mag0;
   logic [rmq_pkg::DEN_W-1:0] den0;
   logic [rmq_pkg::NUM_W-1:0] num0;
   logic [rmq_pkg::QUO_W-1:0] qmag;

   always_comb begin
      neg0 = num_in[rmq_pkg::DIFF_W-1];
      mag0 = neg0 ? rmq_pkg::DIFF_W'(0) - num_in : num_in;
      den0 = {root_in, 2'b00};
      num0 = (rmq_pkg::NUM_W'(mag0) << rmq_pkg::FRAC_BITS)
           + rmq_pkg::NUM_W'(den0 >> 1);
      // Quotient too large for the bit stages: saturate later.
      ovf0 = rmq_pkg::CMP_W'(num0) >= (rmq_pkg::CMP_W'(den0) << NS);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= num0;
         den_ff[0] <= den0;
         quo_ff[0] <= '0;
         neg_ff[0] <= neg0;
         ovf_ff[0] <= ovf0;
      end
   end

   for (genvar s = 0; s < NS; s++) begin : g_stage
      localparam int B = NS - 1 - s;
      logic [rmq_pkg::CMP_W-1:0] sub;
      logic                      ge;

      always_comb begin
         sub = rmq_pkg::CMP_W'(den_ff[s]) << B;
         ge  = rmq_pkg::CMP_W'(rem_ff[s]) >= sub;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s+1] <= ge ? rem_ff[s] - sub[rmq_pkg::NUM_W-1:0] : rem_ff[s];
            quo_ff[s+1] <= ge ? quo_ff[s] | (rmq_pkg::QUO_W'(1) << B) : quo_ff[s];
            den_ff[s+1] <= den_ff[s];
            neg_ff[s+1] <= neg_ff[s];
            ovf_ff[s+1] <= ovf_ff[s];
         end
      end
   end

   always_comb begin
      qmag = quo_ff[NS];
      if (ovf_ff[NS] || quo_ff[NS][rmq_pkg::QUO_W-1]) begin
         quo_out = neg_ff[NS] ? rmq_pkg::OUT_MIN : rmq_pkg::OUT_MAX;
      end else begin
         quo_out = neg_ff[NS] ? rmq_pkg::DATA_W'(0) - signed'(qmag) : signed'(qmag);
      end
   end

endmodule

// ----- src/rotation_matrix_to_quaternion_core.sv -----
// ---------------------------------------------------------------------------
// Rotation matrix to quaternion core
// Converts a 3x3 rotation matrix in signed Q2.16 to a quaternion (x, y, z, w)
// by the trace method, with an invalid flag for a non-positive radicand.
// ---------------------------------------------------------------------------
// The core takes one matrix word per clock and returns one quaternion word per
// clock for as long as the result side keeps ready high. A result passes the
// front-end classification register, which is loaded at the accepting edge,
// the four-entry queue, 18 stages of the bit-per-stage square root with
// rounding, 19 stages of the three parallel bit-per-stage dividers, and the
// output register. Ties between diagonal entries go to the earlier one. A
// non-positive radicand returns the identity quaternion with invalid set.
module rotation_matrix_to_quaternion_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [rmq_pkg::DATA_W-1:0] req_e00,
   input  logic signed [rmq_pkg::DATA_W-1:0] req_e01,
   input  logic signed [rmq_pkg::DATA_W-1:0] req_e02,
   input  logic signed [rmq_pkg::DATA_W-1:0] req_e10,
   input  logic signed [rmq_pkg::DATA_W-1:0] req_e11,
   input  logic signed [rmq_pkg::DATA_W-1:0] req_e12,
   input  logic signed [rmq_pkg::DATA_W-1:0] req_e20,
   input  logic signed [rmq_pkg::DATA_W-1:0] req_e21,
   input  logic signed [rmq_pkg::DATA_W-1:0] req_e22,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [rmq_pkg::DATA_W-1:0] rsp_quat_x,
   output logic signed [rmq_pkg::DATA_W-1:0] rsp_quat_y,
   output logic signed [rmq_pkg::DATA_W-1:0] rsp_quat_z,
   output logic signed [rmq_pkg::DATA_W-1:0] rsp_quat_w,
   output logic                              rsp_invalid
);

   logic signed [rmq_pkg::DATA_W-1:0] ent [9];
   logic                              f_valid, f_ready;
   rmq_pkg::item_type                 f_item, q_item, s_item;
   logic                              q_valid, s_valid, adv;
   logic [rmq_pkg::ROOT_W-1:0]        s_root;
   logic signed [rmq_pkg::DATA_W-1:0] quo0, quo1, quo2;
   rmq_pkg::meta_type                 meta_ff [rmq_pkg::DIV_STAGES];
   rmq_pkg::meta_type                 meta_in, last;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic signed [rmq_pkg::DATA_W-1:0] x_ff, y_ff, z_ff, w_ff, x_in, y_in, z_in, w_in;
   logic signed [rmq_pkg::DATA_W-1:0] root_q;
   logic                              bad_ff;

   always_comb begin
      ent[0] = req_e00;
      ent[1] = req_e01;
      ent[2] = req_e02;
      ent[3] = req_e10;
      ent[4] = req_e11;
      ent[5] = req_e12;
      ent[6] = req_e20;
      ent[7] = req_e21;
      ent[8] = req_e22;
   end

   rmq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .ent       (ent),
      .out_valid (f_valid),
      .out_item  (f_item),
      .out_ready (f_ready)
   );

   rmq_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_item  (f_item),
      .pop_valid  (q_valid),
      .pop_ready  (adv),
      .pop_item   (q_item)
   );

   // The whole back end moves together whenever the output register can take a word.
   assign adv = !rsp_valid_ff || rsp_ready;

   rmq_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (q_valid),
      .in_item   (q_item),
      .out_valid (s_valid),
      .out_item  (s_item),
      .out_root  (s_root)
   );

   rmq_div u_div0 (.clock(clock), .en(adv), .num_in(s_item.d0), .root_in(s_root), .quo_out(quo0));
   rmq_div u_div1 (.clock(clock), .en(adv), .num_in(s_item.d1), .root_in(s_root), .quo_out(quo1));
   rmq_div u_div2 (.clock(clock), .en(adv), .num_in(s_item.d2), .root_in(s_root), .quo_out(quo2));

   always_comb begin
      meta_in.vld  = s_valid;
      meta_in.sel  = s_item.sel;
      meta_in.bad  = s_item.bad;
      meta_in.root = s_root;
   end

   for (genvar s = 0; s < rmq_pkg::DIV_STAGES; s++) begin : g_meta
      rmq_pkg::meta_type prev;

      if (s == 0) begin : g_head
         assign prev = meta_in;
      end else begin : g_body
         assign prev = meta_ff[s-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            meta_ff[s] <= '0;
         end else if (adv) begin
            meta_ff[s] <= prev;
         end
      end
   end

   assign last   = meta_ff[rmq_pkg::DIV_STAGES-1];
   assign root_q = rmq_pkg::DATA_W'(last.root);

   always_comb begin
      rsp_valid_in = last.vld;
      x_in = '0;
      y_in = '0;
      z_in = '0;
      w_in = rmq_pkg::ONE_Q;
      if (!last.bad) begin
         unique case (last.sel)
            rmq_pkg::SEL_W: begin
               x_in = quo0;
               y_in = quo1;
               z_in = quo2;
               w_in = root_q;
            end
            rmq_pkg::SEL_X: begin
               x_in = root_q;
               w_in = quo0;
               y_in = quo1;
               z_in = quo2;
            end
            rmq_pkg::SEL_Y: begin
               y_in = root_q;
               w_in = quo0;
               z_in = quo1;
               x_in = quo2;
            end
            rmq_pkg::SEL_Z: begin
               z_in = root_q;
               w_in = quo0;
               x_in = quo1;
               y_in = quo2;
            end
            default: begin
               w_in = root_q;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         z_ff   <= z_in;
         w_ff   <= w_in;
         bad_ff <= last.bad;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_quat_x  = x_ff;
   assign rsp_quat_y  = y_ff;
   assign rsp_quat_z  = z_ff;
   assign rsp_quat_w  = w_ff;
   assign rsp_invalid = bad_ff;

   a_identity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_invalid |->
         rsp_quat_x == 0 && rsp_quat_y == 0 && rsp_quat_z == 0 && rsp_quat_w == rmq_pkg::ONE_Q)
      else $error("invalid word without identity quaternion");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word valid right after reset");

endmodule
